### rtl/lcr_pkg.sv
// lcr_pkg: shared constants, payload types and control/status structs
// for the looped catmull-rom path walker; no dependencies
package lcr_pkg;

    localparam int POINTS      = 64;
    localparam int T_FRAC_BITS = 16;

    localparam int PT_AW    = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int PATH_MAX = (POINTS < 64) ? POINTS : 64;

    localparam int CW     = 24;
    localparam int IDX_W  = 6;
    localparam int TIME_W = 48;
    localparam int CNT_W  = 7;
    localparam int SPD_W  = 16;
    localparam int SEG_W  = 6;
    localparam int TP_W   = 16;
    localparam int AXES   = 3;

    localparam int CA_W = 25;
    localparam int CB_W = 28;
    localparam int CC_W = 27;
    localparam int OP_W = 30;
    localparam int FV_W = 31;

    localparam int HALF_W    = TIME_W / 2;
    localparam int PP_W      = HALF_W + SPD_W;
    localparam int PROD_W    = TIME_W + SPD_W;
    localparam int DELTA_W   = PROD_W - (32 - T_FRAC_BITS);
    localparam int TOT_W     = DELTA_W + 1;
    localparam int WHOLE_W   = TOT_W - T_FRAC_BITS;
    localparam int REM_DIG   = 4;
    localparam int REM_STEPS = (WHOLE_W + REM_DIG - 1) / REM_DIG;
    localparam int REM_PAD_W = REM_STEPS * REM_DIG;
    localparam int REM_CW    = $clog2(REM_STEPS + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_STEP    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_SPEED       = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd4;
    localparam logic [SPD_W-1:0] SPEED_RESET = 16'd16384;

    localparam logic [1:0] ADV_LO  = 2'd0;
    localparam logic [1:0] ADV_HI  = 2'd1;
    localparam logic [1:0] ADV_SUM = 2'd2;
    localparam logic [1:0] ADV_TOT = 2'd3;

    localparam logic [1:0] STEP_C = 2'd0;
    localparam logic [1:0] STEP_B = 2'd1;
    localparam logic [1:0] STEP_A = 2'd2;

    localparam logic [1:0] LAST_AXIS = 2'd2;

    localparam int         RD_CW   = 3;
    localparam logic [2:0] RD_LAST = 3'd4;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        point_index;
        logic signed [CW-1:0]    point_x;
        logic signed [CW-1:0]    point_y;
        logic signed [CW-1:0]    point_z;
        logic [TIME_W-1:0]       app_time;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0]    pos_x;
        logic signed [CW-1:0]    pos_y;
        logic signed [CW-1:0]    pos_z;
        logic [SEG_W-1:0]        segment;
        logic [TP_W-1:0]         t_param;
    } t_out_item;

    // element 0 is x, 1 is y, 2 is z
    typedef logic [AXES-1:0][CW-1:0] t_point;

    typedef struct packed {
        logic       take;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       adv_en;
        logic [1:0] adv_sel;
        logic       coef_en;
        logic       rem_start;
        logic       mul_en;
        logic [1:0] mul_axis;
        logic [1:0] mul_step;
        logic       fin_en;
        logic [1:0] fin_axis;
        logic       done;
    } t_cmd;

    typedef struct packed {
        logic rem_done;
        logic out_free;
    } t_stat;

endpackage

### rtl/looped_catmull_rom_path_walker_unit.sv
// looped_catmull_rom_path_walker_unit: top level, joins registers,
// sequencer and datapath; depends on lcr_pkg, lcr_regs, lcr_ctrl, lcr_dpath
//
// Walks a closed catmull-rom path over up to POINTS control points held in a
// single-port memory. A load, restart or unused-mode transaction leaves the
// input ready. A time step transaction goes, from acceptance until its
// result is registered, through the four point reads on the one memory
// read port, coefficient setup, nine passes through the shared multiplier
// (three per axis), the last axis rounding and the hand-off; the segment
// remainder unit runs alongside. The next transaction is accepted once the
// result is registered; if the previous result has not been taken, the
// hand-off waits for it. Point slots are not cleared by reset and read back
// undefined until loaded.
module looped_catmull_rom_path_walker_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lcr_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lcr_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcr_pkg::PADDR_W-1:0] paddr,
    input  logic [lcr_pkg::PDATA_W-1:0] pwdata,
    output logic [lcr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [lcr_pkg::CNT_W-1:0] point_count;
    logic [lcr_pkg::SPD_W-1:0] speed;
    lcr_pkg::t_cmd             cmd;
    lcr_pkg::t_stat            stat;

    lcr_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_point_count (point_count),
        .o_speed       (speed)
    );

    lcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_data.mode),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    lcr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_data     (i_in_data),
        .i_point_count (point_count),
        .i_speed       (speed),
        .i_out_ready   (i_out_ready),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

### rtl/lcr_regs.sv
// lcr_regs: apb-style configuration registers (point count, speed)
// depends on lcr_pkg
module lcr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcr_pkg::PADDR_W-1:0] paddr,
    input  logic [lcr_pkg::PDATA_W-1:0] pwdata,
    output logic [lcr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [lcr_pkg::CNT_W-1:0]   o_point_count,
    output logic [lcr_pkg::SPD_W-1:0]   o_speed
);

    logic [lcr_pkg::CNT_W-1:0] r_point_count;
    logic [lcr_pkg::SPD_W-1:0] r_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= lcr_pkg::COUNT_RESET;
            r_speed       <= lcr_pkg::SPEED_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[lcr_pkg::PADDR_W-1])
                lcr_pkg::REG_POINT_COUNT: r_point_count <= pwdata[lcr_pkg::CNT_W-1:0];
                lcr_pkg::REG_SPEED:       r_speed       <= pwdata[lcr_pkg::SPD_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[lcr_pkg::PADDR_W-1])
            lcr_pkg::REG_POINT_COUNT: prdata = lcr_pkg::PDATA_W'(r_point_count);
            lcr_pkg::REG_SPEED:       prdata = lcr_pkg::PDATA_W'(r_speed);
        endcase
    end

    assign pready        = 1'b1;
    assign o_point_count = r_point_count;
    assign o_speed       = r_speed;

endmodule

### rtl/lcr_ctrl.sv
// lcr_ctrl: sequencer for one transaction: point reads, coefficient setup,
// shared multiplier passes and result hand-off; depends on lcr_pkg
module lcr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_mode,
    input  lcr_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output lcr_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COEF,
        S_MUL,
        S_FIN,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [lcr_pkg::RD_CW-1:0] r_cnt;
    logic [1:0]                r_axis;
    logic [1:0]                r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
            r_step  <= lcr_pkg::STEP_C;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_in_mode == lcr_pkg::MODE_STEP) begin
                        r_state <= S_READ;
                        r_cnt   <= '0;
                    end
                end
                S_READ: begin
                    if (r_cnt == lcr_pkg::RD_LAST) begin
                        r_state <= S_COEF;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_COEF: begin
                    r_state <= S_MUL;
                    r_axis  <= '0;
                    r_step  <= lcr_pkg::STEP_C;
                end
                S_MUL: begin
                    if (r_step == lcr_pkg::STEP_A) begin
                        r_step <= lcr_pkg::STEP_C;
                        if (r_axis == lcr_pkg::LAST_AXIS) begin
                            r_state <= S_FIN;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_stat.rem_done && i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid;
            end
            S_READ: begin
                o_cmd.rd_en   = ~r_cnt[2];
                o_cmd.rd_sel  = r_cnt[1:0];
                o_cmd.cap_en  = (r_cnt != '0);
                o_cmd.cap_sel = 2'(r_cnt - 3'd1);
                o_cmd.adv_en  = ~r_cnt[2];
                o_cmd.adv_sel = r_cnt[1:0];
            end
            S_COEF: begin
                o_cmd.coef_en   = 1'b1;
                o_cmd.rem_start = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_axis = r_axis;
                o_cmd.mul_step = r_step;
                o_cmd.fin_en   = (r_step == lcr_pkg::STEP_C) && (r_axis != 2'd0);
                o_cmd.fin_axis = r_axis - 2'd1;
            end
            S_FIN: begin
                o_cmd.fin_en   = 1'b1;
                o_cmd.fin_axis = lcr_pkg::LAST_AXIS;
            end
            S_DONE: begin
                o_cmd.done = i_stat.rem_done && i_stat.out_free;
            end
        endcase
    end

endmodule

### rtl/lcr_dpath.sv
// lcr_dpath: point memory, path state, time advance, segment remainder unit,
// shared interpolation multiplier and output register; depends on lcr_pkg
module lcr_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lcr_pkg::t_cmd             i_cmd,
    input  lcr_pkg::t_in_item         i_in_data,
    input  logic [lcr_pkg::CNT_W-1:0] i_point_count,
    input  logic [lcr_pkg::SPD_W-1:0] i_speed,
    input  logic                      i_out_ready,
    output lcr_pkg::t_stat            o_stat,
    output logic                      o_out_valid,
    output lcr_pkg::t_out_item        o_out_data
);

    localparam int F = lcr_pkg::T_FRAC_BITS;

    lcr_pkg::t_point r_mem [lcr_pkg::POINTS];
    lcr_pkg::t_point r_rd;
    lcr_pkg::t_point r_p [4];

    logic [lcr_pkg::PT_AW-1:0]  r_ridx [4];
    logic [F-1:0]               r_t;
    logic [lcr_pkg::SEG_W-1:0]  r_seg;
    logic [lcr_pkg::TIME_W-1:0] r_last;
    logic                       r_have_last;
    logic [lcr_pkg::CNT_W-1:0]  r_len;
    logic [lcr_pkg::SEG_W-1:0]  r_s;
    logic [lcr_pkg::TIME_W-1:0] r_elapsed;

    logic [lcr_pkg::PP_W-1:0]   r_pp_lo;
    logic [lcr_pkg::PP_W-1:0]   r_pp_hi;
    logic [lcr_pkg::PROD_W-1:0] r_prod;
    logic [lcr_pkg::TOT_W-1:0]  r_total;

    logic [lcr_pkg::REM_PAD_W-1:0] r_rem_word;
    logic [lcr_pkg::CNT_W-1:0]     r_rem_acc;
    logic [lcr_pkg::REM_CW-1:0]    r_rem_cnt;

    logic signed [lcr_pkg::CA_W-1:0] r_ca [lcr_pkg::AXES];
    logic signed [lcr_pkg::CB_W-1:0] r_cb [lcr_pkg::AXES];
    logic signed [lcr_pkg::CC_W-1:0] r_cc [lcr_pkg::AXES];
    logic signed [lcr_pkg::OP_W-1:0] r_h;
    logic [lcr_pkg::CW-1:0]          r_pos [lcr_pkg::AXES];

    lcr_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic [lcr_pkg::CNT_W-1:0]  len;
    logic [lcr_pkg::CNT_W-1:0]  s_cur;
    logic [lcr_pkg::CNT_W-1:0]  s_p1;
    logic [lcr_pkg::CNT_W-1:0]  s_p2;
    logic [lcr_pkg::CNT_W-1:0]  i0;
    logic [lcr_pkg::CNT_W-1:0]  i2;
    logic [lcr_pkg::CNT_W-1:0]  i3;
    logic [lcr_pkg::TIME_W-1:0] elapsed;
    logic                       idx_ok;
    logic [lcr_pkg::HALF_W-1:0] half;
    logic [lcr_pkg::PP_W-1:0]   pp;
    logic [lcr_pkg::CNT_W-1:0]  rem_v;
    logic [lcr_pkg::CNT_W-1:0]  seg_sum;
    logic [lcr_pkg::CNT_W-1:0]  seg_next;

    logic signed [lcr_pkg::OP_W-1:0]   op;
    logic signed [lcr_pkg::OP_W+F:0]   prod;
    logic signed [lcr_pkg::FV_W-1:0]   fv;
    logic [lcr_pkg::FV_W-2:0]          fq;
    logic [lcr_pkg::FV_W-lcr_pkg::CW-1:0] fq_hi;
    logic [lcr_pkg::CW-1:0]            fsat;
    logic [F+lcr_pkg::TP_W-1:0]        t_wide;

    function automatic logic signed [lcr_pkg::OP_W-1:0] sx(input logic [lcr_pkg::CW-1:0] v);
        return lcr_pkg::OP_W'($signed(v));
    endfunction

    // path length and neighbor slots of the current segment
    always_comb begin
        if (i_point_count < lcr_pkg::CNT_W'(2)) begin
            len = lcr_pkg::CNT_W'(2);
        end else if (i_point_count > lcr_pkg::CNT_W'(lcr_pkg::PATH_MAX)) begin
            len = lcr_pkg::CNT_W'(lcr_pkg::PATH_MAX);
        end else begin
            len = i_point_count;
        end
        s_cur = (lcr_pkg::CNT_W'(r_seg) >= len) ? '0 : lcr_pkg::CNT_W'(r_seg);
        s_p1  = s_cur + 7'd1;
        s_p2  = s_cur + 7'd2;
        i0    = (s_cur == '0) ? '0 : s_cur - 7'd1;
        i2    = (s_p1 == len) ? '0 : s_p1;
        i3    = (s_p2 >= len) ? s_p2 - len : s_p2;
        if (r_have_last && i_in_data.app_time > r_last) begin
            elapsed = i_in_data.app_time - r_last;
        end else begin
            elapsed = '0;
        end
        idx_ok = int'(i_in_data.point_index) < lcr_pkg::POINTS;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_in_data.mode == lcr_pkg::MODE_LOAD && idx_ok) begin
            r_mem[lcr_pkg::PT_AW'(i_in_data.point_index)] <=
                {i_in_data.point_z, i_in_data.point_y, i_in_data.point_x};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_ridx[i_cmd.rd_sel]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_in_data.mode == lcr_pkg::MODE_STEP) begin
            r_ridx[0] <= lcr_pkg::PT_AW'(i0);
            r_ridx[1] <= lcr_pkg::PT_AW'(s_cur);
            r_ridx[2] <= lcr_pkg::PT_AW'(i2);
            r_ridx[3] <= lcr_pkg::PT_AW'(i3);
            r_len     <= len;
            r_s       <= lcr_pkg::SEG_W'(s_cur);
            r_elapsed <= elapsed;
        end
        if (i_cmd.cap_en) begin
            r_p[i_cmd.cap_sel] <= r_rd;
        end
    end

    // path state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t         <= '0;
            r_seg       <= '0;
            r_last      <= '0;
            r_have_last <= 1'b0;
        end else if (i_cmd.done) begin
            r_t   <= r_total[F-1:0];
            r_seg <= lcr_pkg::SEG_W'(seg_next);
        end else if (i_cmd.take && i_in_data.mode == lcr_pkg::MODE_RESTART) begin
            r_t         <= '0;
            r_seg       <= '0;
            r_have_last <= 1'b0;
        end else if (i_cmd.take && i_in_data.mode == lcr_pkg::MODE_STEP) begin
            r_last      <= i_in_data.app_time;
            r_have_last <= 1'b1;
        end
    end

    // time advance: elapsed times speed in two half-width partial products
    assign half = (i_cmd.adv_sel == lcr_pkg::ADV_LO) ? r_elapsed[lcr_pkg::HALF_W-1:0]
                                                     : r_elapsed[lcr_pkg::TIME_W-1:lcr_pkg::HALF_W];
    assign pp   = half * i_speed;

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv_en) begin
            unique case (i_cmd.adv_sel)
                lcr_pkg::ADV_LO:  r_pp_lo <= pp;
                lcr_pkg::ADV_HI:  r_pp_hi <= pp;
                lcr_pkg::ADV_SUM: r_prod  <= {r_pp_hi, lcr_pkg::HALF_W'(0)}
                                             + lcr_pkg::PROD_W'(r_pp_lo);
                lcr_pkg::ADV_TOT: r_total <= lcr_pkg::TOT_W'(r_t)
                                             + lcr_pkg::TOT_W'(r_prod[lcr_pkg::PROD_W-1:32-F]);
            endcase
        end
    end

    // whole segments mod path length, REM_DIG bits per cycle
    always_comb begin
        rem_v = r_rem_acc;
        for (int j = 0; j < lcr_pkg::REM_DIG; j++) begin
            rem_v = {rem_v[lcr_pkg::CNT_W-2:0], r_rem_word[lcr_pkg::REM_PAD_W-1-j]};
            if (rem_v >= r_len) begin
                rem_v = rem_v - r_len;
            end
        end
        seg_sum  = lcr_pkg::CNT_W'(r_s) + r_rem_acc;
        seg_next = (seg_sum >= r_len) ? seg_sum - r_len : seg_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_cnt <= '0;
        end else if (i_cmd.rem_start) begin
            r_rem_word <= lcr_pkg::REM_PAD_W'(r_total[lcr_pkg::TOT_W-1:F]);
            r_rem_acc  <= '0;
            r_rem_cnt  <= lcr_pkg::REM_CW'(lcr_pkg::REM_STEPS);
        end else if (r_rem_cnt != '0) begin
            r_rem_word <= r_rem_word << lcr_pkg::REM_DIG;
            r_rem_acc  <= rem_v;
            r_rem_cnt  <= r_rem_cnt - 1'b1;
        end
    end

    // per axis coefficients
    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_en) begin
            for (int k = 0; k < lcr_pkg::AXES; k++) begin
                r_ca[k] <= lcr_pkg::CA_W'(sx(r_p[2][k]) - sx(r_p[0][k]));
                r_cb[k] <= lcr_pkg::CB_W'((sx(r_p[0][k]) <<< 1)
                                          - ((sx(r_p[1][k]) <<< 2) + sx(r_p[1][k]))
                                          + (sx(r_p[2][k]) <<< 2)
                                          - sx(r_p[3][k]));
                r_cc[k] <= lcr_pkg::CC_W'((sx(r_p[3][k]) - sx(r_p[0][k]))
                                          + ((sx(r_p[1][k]) - sx(r_p[2][k])) <<< 1)
                                          + (sx(r_p[1][k]) - sx(r_p[2][k])));
            end
        end
    end

    // horner passes through the shared multiplier
    always_comb begin
        unique case (i_cmd.mul_step)
            lcr_pkg::STEP_C: op = lcr_pkg::OP_W'(r_cc[i_cmd.mul_axis]);
            lcr_pkg::STEP_B: op = lcr_pkg::OP_W'(r_cb[i_cmd.mul_axis]) + r_h;
            lcr_pkg::STEP_A: op = lcr_pkg::OP_W'(r_ca[i_cmd.mul_axis]) + r_h;
            default:         op = '0;
        endcase
        prod = op * $signed({1'b0, r_t});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_h <= $signed(prod[lcr_pkg::OP_W+F-1:F]);
        end
    end

    // rounding and saturation of the finished axis
    always_comb begin
        fv    = lcr_pkg::FV_W'($signed({r_p[1][i_cmd.fin_axis], 1'b1}))
                + lcr_pkg::FV_W'(r_h);
        fq    = fv[lcr_pkg::FV_W-1:1];
        fq_hi = fq[lcr_pkg::FV_W-2:lcr_pkg::CW-1];
        if ((&fq_hi) || !(|fq_hi)) begin
            fsat = fq[lcr_pkg::CW-1:0];
        end else if (fq[lcr_pkg::FV_W-2]) begin
            fsat = {1'b1, {(lcr_pkg::CW-1){1'b0}}};
        end else begin
            fsat = {1'b0, {(lcr_pkg::CW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_en) begin
            r_pos[i_cmd.fin_axis] <= fsat;
        end
    end

    assign t_wide = {r_t, lcr_pkg::TP_W'(0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_out.pos_x   <= r_pos[0];
            r_out.pos_y   <= r_pos[1];
            r_out.pos_z   <= r_pos[2];
            r_out.segment <= r_s;
            r_out.t_param <= t_wide[F+lcr_pkg::TP_W-1:F];
        end
    end

    assign o_stat.rem_done = (r_rem_cnt == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

### rtl/lcr_chk.sv
// lcr_chk: port-level checks of the path walker top level
// depends on lcr_pkg; bound to looped_catmull_rom_path_walker_unit
module lcr_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input lcr_pkg::t_in_item           i_in_data,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input lcr_pkg::t_out_item          o_out_data
);

    a_step_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.mode == lcr_pkg::MODE_STEP) |=> !o_in_ready)
        else $error("input still ready after a step transaction");

    a_other_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.mode != lcr_pkg::MODE_STEP) |=> o_in_ready)
        else $error("input not ready after a non-step transaction");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a step in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind looped_catmull_rom_path_walker_unit lcr_chk u_chk (.*);

### bench/lcr_path_checker.sv
// lcr_path_checker: follows the input, result and apb channels of the path walker,
// keeps its own copy of points, walk state and registers, and compares each position
// depends on lcr_pkg
module lcr_path_checker
    import lcr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_item           i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_item          i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_pending,
    output int                 o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_HI = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_LO = -(longint'(1) << (CW - 1));

    t_point                 point_store [POINTS];
    logic [T_FRAC_BITS-1:0] t_accum;
    logic [SEG_W-1:0]       cur_segment;
    logic [TIME_W-1:0]      last_time;
    logic                   have_last;
    logic [CNT_W-1:0]       point_count;
    logic [SPD_W-1:0]       speed;
    t_out_item              expected_positions [$];
    int                     mismatch_count = 0;

    function automatic logic signed [CW-1:0] blend_axis(longint p0, longint p1, longint p2,
                                                        longint p3, longint t);
        longint a, b, c, h, v;
        a = p2 - p0;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = -p0 + 3 * p1 - 3 * p2 + p3;
        h = (c * t) >>> T_FRAC_BITS;
        h = ((b + h) * t) >>> T_FRAC_BITS;
        h = ((a + h) * t) >>> T_FRAC_BITS;
        v = (2 * p1 + h + 1) >>> 1;
        if (v > COORD_HI) begin
            v = COORD_HI;
        end
        if (v < COORD_LO) begin
            v = COORD_LO;
        end
        return v[CW-1:0];
    endfunction

    task automatic take_step(logic [TIME_W-1:0] now);
        logic [63:0]             elapsed, delta, total, whole;
        int unsigned             n, s, i0, i2, i3;
        longint                  t;
        logic signed [CW-1:0]    pos [AXES];
        t_out_item               r;
        elapsed = '0;
        if (have_last && now > last_time) begin
            elapsed = now - last_time;
        end
        last_time = now;
        have_last = 1'b1;

        n = point_count;
        if (n < 2) begin
            n = 2;
        end
        if (n > PATH_MAX) begin
            n = PATH_MAX;
        end
        s = cur_segment;
        if (s >= n) begin
            s = 0;
        end
        i0 = (s == 0) ? 0 : s - 1;
        i2 = (s + 1) % n;
        i3 = (s + 2) % n;
        t  = t_accum;

        for (int k = 0; k < AXES; k++) begin
            pos[k] = blend_axis($signed(point_store[i0][k]), $signed(point_store[s][k]),
                                $signed(point_store[i2][k]), $signed(point_store[i3][k]), t);
        end
        r.pos_x   = pos[0];
        r.pos_y   = pos[1];
        r.pos_z   = pos[2];
        r.segment = SEG_W'(s);
        r.t_param = TP_W'(t_accum);
        expected_positions.push_back(r);

        delta       = (elapsed * speed) >> (32 - T_FRAC_BITS);
        total       = t_accum + delta;
        whole       = total >> T_FRAC_BITS;
        t_accum     = total[T_FRAC_BITS-1:0];
        cur_segment = SEG_W'((s + whole % n) % n);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_positions.size() == 0) begin
            $error("result with no step waiting: segment %0d t_param %0d",
                   got.segment, got.t_param);
            mismatch_count++;
        end else begin
            want = expected_positions.pop_front();
            check_field("pos_x", $signed(want.pos_x), $signed(got.pos_x));
            check_field("pos_y", $signed(want.pos_y), $signed(got.pos_y));
            check_field("pos_z", $signed(want.pos_z), $signed(got.pos_z));
            check_field("segment", want.segment, got.segment);
            check_field("t_param", want.t_param, got.t_param);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            t_accum     = '0;
            cur_segment = '0;
            last_time   = '0;
            have_last   = 1'b0;
            point_count = COUNT_RESET;
            speed       = SPEED_RESET;
            expected_positions.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.mode)
                    MODE_LOAD: begin
                        if (int'(i_in_data.point_index) < POINTS) begin
                            point_store[i_in_data.point_index][0] = i_in_data.point_x;
                            point_store[i_in_data.point_index][1] = i_in_data.point_y;
                            point_store[i_in_data.point_index][2] = i_in_data.point_z;
                        end
                    end
                    MODE_STEP: begin
                        take_step(i_in_data.app_time);
                    end
                    MODE_RESTART: begin
                        t_accum     = '0;
                        cur_segment = '0;
                        have_last   = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_POINT_COUNT: point_count = i_pwdata[CNT_W-1:0];
                    REG_SPEED:       speed = i_pwdata[SPD_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_positions.size();
        o_mismatches <= mismatch_count;
    end

endmodule

### bench/tb_looped_catmull_rom_path_walker_unit.sv
// tb_looped_catmull_rom_path_walker_unit: drives point loads, time steps, restarts,
// unused-mode items and register writes into the path walker, with random idling on both channels
// depends on lcr_pkg, lcr_path_checker and looped_catmull_rom_path_walker_unit
module tb_looped_catmull_rom_path_walker_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import lcr_pkg::*;

    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 24;
    localparam int         PHASES         = 10;
    localparam int         PHASE_ITEMS    = 167;
    localparam int         COORD_MAX      = (1 << (CW - 1)) - 1;
    localparam int         COORD_MIN      = -(1 << (CW - 1));
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 queued_results;
    int                 mismatch_total;
    logic               calm         = 1'b0;
    int                 stall_left   = 0;
    int                 cycle_count  = 0;
    int                 quiet_cycles = 0;
    logic [TIME_W-1:0]  time_now     = '0;
    logic [POINTS-1:0]  slot_loaded  = '0;
    int                 n_sent       = 0;
    int                 n_steps      = 0;
    int                 n_loads      = 0;
    int                 n_restarts   = 0;
    int                 n_unused     = 0;

    int phase_count [PHASES] = '{64, 2, 0, 127, 1, 5, 33, 64, 3, 16};
    int phase_speed [PHASES] = '{65535, 0, 30000, 1, 65535, 21845, 47000, 12000, 50000, 40000};

    looped_catmull_rom_path_walker_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lcr_path_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (queued_results),
        .o_mismatches (mismatch_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || calm) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ((cycle_count / 600) % 4 != 3 && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("looped_catmull_rom_path_walker_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item make_item(logic [1:0] mode, int idx, int x, int y, int z,
                                           logic [TIME_W-1:0] at);
        t_in_item it;
        it.mode        = mode;
        it.point_index = IDX_W'(idx);
        it.point_x     = CW'(x);
        it.point_y     = CW'(y);
        it.point_z     = CW'(z);
        it.app_time    = at;
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3:    return int'($urandom);
            default: return int'($urandom_range(0, 131071)) - 65536;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] next_time();
        case ($urandom_range(0, 19))
            0:       time_now = time_now - $urandom_range(0, 'h40000);
            1:       time_now = TIME_W'({$urandom, $urandom});
            2:       ;
            default: time_now = time_now + $urandom_range(0, 'h80000);
        endcase
        return time_now;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it = make_item(MODE_STEP, $urandom_range(0, 63), rand_coord(), rand_coord(),
                       rand_coord(), TIME_W'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            it.app_time = next_time();
        end else if (pick < 87) begin
            it.mode = MODE_LOAD;
        end else if (pick < 94) begin
            it.mode = MODE_RESTART;
        end else begin
            it.mode = MODE_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        case (it.mode)
            MODE_LOAD: begin
                n_loads++;
                slot_loaded[it.point_index] = 1'b1;
            end
            MODE_STEP:    n_steps++;
            MODE_RESTART: n_restarts++;
            default:      n_unused++;
        endcase
        if (!calm && (n_sent / 80) % 3 != 2 && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic regsel, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({regsel, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (queued_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int       eff_points;
        int       done;
        t_in_item it;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // overshooting neighbors drive segment 1 into saturation on x and y
        send_item(make_item(MODE_LOAD, 0, COORD_MIN, COORD_MAX, 0, '0));
        send_item(make_item(MODE_LOAD, 1, COORD_MAX, COORD_MIN, 256, '0));
        send_item(make_item(MODE_LOAD, 2, COORD_MAX, COORD_MIN, -1, '0));
        send_item(make_item(MODE_LOAD, 3, COORD_MIN, COORD_MAX, 'h12345, '0));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'h0000_0000_0000));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'h0000_0001_8000));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'h0000_0003_0000));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'h0000_0001_0000));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'h0000_0005_0000));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
        send_item(make_item(MODE_UNUSED, 63, COORD_MAX, COORD_MAX, COORD_MAX,
                            48'hFFFF_FFFF_FFFF));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
        send_item(make_item(MODE_RESTART, 0, 0, 0, 0, '0));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'h8000_0000_0000));
        send_item(make_item(MODE_LOAD, 63, COORD_MAX, COORD_MIN, COORD_MAX, '0));
        send_item(make_item(MODE_STEP, 0, 0, 0, 0, 48'h8000_0002_0000));
        time_now = 48'h8000_0002_0000;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_POINT_COUNT, phase_count[p]);
            write_reg(REG_SPEED, phase_speed[p]);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            if (p == PHASES - 1) begin
                calm <= 1'b1;
            end
            eff_points = (phase_count[p] < 2) ? 2 :
                         (phase_count[p] > PATH_MAX) ? PATH_MAX : phase_count[p];
            // every slot on the path gets a point before any step reads it
            for (int i = 0; i < eff_points; i++) begin
                if (!slot_loaded[i]) begin
                    send_item(make_item(MODE_LOAD, i, rand_coord(), rand_coord(),
                                        rand_coord(), '0));
                end
            end
            done = 0;
            while (done < PHASE_ITEMS) begin
                it = random_item();
                send_item(it);
                if (it.mode != MODE_UNUSED) begin
                    done++;
                end
            end
        end
        settle();

        $display("covered %0d time steps, %0d point loads, %0d restarts, %0d unused-mode transactions",
                 n_steps, n_loads, n_restarts, n_unused);
        $display("over %0d register settings, point counts clamped at both ends, speed 0 to max",
                 PHASES + 1);
        if (mismatch_total == 0 && queued_results == 0) begin
            $display("looped_catmull_rom_path_walker_unit test passed");
        end else begin
            $display("looped_catmull_rom_path_walker_unit test failed");
        end
        $finish;
    end

endmodule
